### design/conv3x3_kernel_filter_assert.svh
// ----------------------------------------------------------------------------
// conv3x3_kernel_filter assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_KERNEL_FILTER_ASSERT_SVH
`define CONV3X3_KERNEL_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
// property holds on every clock edge outside reset
`define C3K_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("conv3x3_kernel_filter: assertion failed");
// trigger in one cycle implies consequent in the next
`define C3K_ASSERT_NEXT(name, clk, rst_n, trig, conseq) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (conseq)) \
        else $error("conv3x3_kernel_filter: assertion failed");
`else
`define C3K_ASSERT(name, clk, rst_n, prop)
`define C3K_ASSERT_NEXT(name, clk, rst_n, trig, conseq)
`endif
`endif

### design/c3k_pkg.sv
// ----------------------------------------------------------------------------
// c3k_pkg
// Shared types, kernel weights and scaling constants of the 3x3 filter.
// ----------------------------------------------------------------------------
package c3k_pkg;

    // Default frame limits
    localparam int C3K_MAX_WIDTH  = 2048;
    localparam int C3K_MAX_HEIGHT = 2048;

    localparam int PIX_W = 8;
    localparam int CFG_W = 12;
    // Signed kernel sum spans -2040..4080
    localparam int SUM_W = 13;
    // Reciprocal scaling: q = (x * RECIP) >> RECIP_SHIFT, exact for x < 4096
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_FILTER_MODE  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 12'd2048;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 12'd2048;

    typedef enum logic [1:0] {
        MODE_BOX,
        MODE_GAUSS,
        MODE_SHARPEN,
        MODE_MEAN_REMOVAL
    } c3k_mode_t;

    // Position marks that travel with each pixel through the pipeline
    typedef struct packed {
        logic produce;   // window is complete: a result follows
        logic eor;       // last result of an output row
        logic eof;       // last result of the frame
    } c3k_tag_t;

    typedef struct packed {
        logic             eof;
        logic             eor;
        logic [PIX_W-1:0] pixel;
    } c3k_result_t;

    // Kernel weights, [mode][row][column]; row 0 is the oldest line
    localparam logic signed [4:0] KERNEL [4][3][3] = '{
        '{'{5'sd1, 5'sd1, 5'sd1}, '{5'sd1, 5'sd1, 5'sd1}, '{5'sd1, 5'sd1, 5'sd1}},
        '{'{5'sd1, 5'sd2, 5'sd1}, '{5'sd2, 5'sd4, 5'sd2}, '{5'sd1, 5'sd2, 5'sd1}},
        '{'{5'sd0, -5'sd2, 5'sd0}, '{-5'sd2, 5'sd11, -5'sd2}, '{5'sd0, -5'sd2, 5'sd0}},
        '{'{-5'sd1, -5'sd1, -5'sd1}, '{-5'sd1, 5'sd9, -5'sd1}, '{-5'sd1, -5'sd1, -5'sd1}}
    };

    // 2^16 / divisor, rounded up: /9, /16, /3, /1
    localparam logic [RECIP_W-1:0] RECIP [4] = '{
        17'd7282, 17'd4096, 17'd21846, 17'd65536
    };

endpackage

### design/c3k_line_buf.sv
// ----------------------------------------------------------------------------
// c3k_line_buf
// Two line memories holding the rows one and two above the current pixel.
// ----------------------------------------------------------------------------
module c3k_line_buf #(
    parameter int DEPTH = c3k_pkg::C3K_MAX_WIDTH
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [c3k_pkg::PIX_W-1:0]    wr_px,
    output logic [c3k_pkg::PIX_W-1:0]    upper_q,
    output logic [c3k_pkg::PIX_W-1:0]    middle_q
);

    logic [c3k_pkg::PIX_W-1:0] upper_mem  [DEPTH];
    logic [c3k_pkg::PIX_W-1:0] middle_mem [DEPTH];

    // Registered read; holds while the pipeline stalls
    always_ff @(posedge aclk) begin
        if (en) begin
            upper_q  <= upper_mem[rd_addr];
            middle_q <= middle_mem[rd_addr];
        end
    end

    // Rows move up by one: middle row drops to upper, new pixel into middle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_addr]  <= middle_q;
            middle_mem[wr_addr] <= wr_px;
        end
    end

endmodule

### design/c3k_window_sum.sv
// ----------------------------------------------------------------------------
// c3k_window_sum
// 3x3 window shift register and registered weighted kernel sum.
// ----------------------------------------------------------------------------
module c3k_window_sum (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [c3k_pkg::PIX_W-1:0]          in_px,
    input  logic [c3k_pkg::PIX_W-1:0]          in_upper,
    input  logic [c3k_pkg::PIX_W-1:0]          in_middle,
    input  c3k_pkg::c3k_tag_t                  in_tag,
    input  c3k_pkg::c3k_mode_t                 mode,
    output logic                               out_valid,
    output logic signed [c3k_pkg::SUM_W-1:0]   out_sum,
    output c3k_pkg::c3k_mode_t                 out_mode,
    output c3k_pkg::c3k_tag_t                  out_tag
);

    logic [c3k_pkg::PIX_W-1:0]        win_reg [3][3];
    logic [c3k_pkg::PIX_W-1:0]        new_col [3];
    logic                             w_valid_reg;
    c3k_pkg::c3k_tag_t                w_tag_reg;
    logic                             s_valid_reg;
    logic signed [c3k_pkg::SUM_W-1:0] s_sum_reg;
    logic signed [c3k_pkg::SUM_W-1:0] s_sum_next;
    c3k_pkg::c3k_mode_t               s_mode_reg;
    c3k_pkg::c3k_tag_t                s_tag_reg;

    assign new_col[0] = in_upper;
    assign new_col[1] = in_middle;
    assign new_col[2] = in_px;

    // Window shifts left by one column per pixel
    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
                win_reg[i][2] <= new_col[i];
            end
        end
    end

    // Nine weighted taps, summed
    always_comb begin
        s_sum_next = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s_sum_next = s_sum_next
                    + c3k_pkg::SUM_W'(c3k_pkg::KERNEL[mode][i][j])
                    * c3k_pkg::SUM_W'($signed({1'b0, win_reg[i][j]}));
            end
        end
    end

    // Stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end else if (en) begin
            w_valid_reg <= in_valid;
            s_valid_reg <= w_valid_reg;
        end
    end

    // Stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            w_tag_reg  <= in_tag;
            s_tag_reg  <= w_tag_reg;
            s_sum_reg  <= s_sum_next;
            s_mode_reg <= mode;
        end
    end

    assign out_valid = s_valid_reg;
    assign out_sum   = s_sum_reg;
    assign out_mode  = s_mode_reg;
    assign out_tag   = s_tag_reg;

endmodule

### design/c3k_scale_clamp.sv
// ----------------------------------------------------------------------------
// c3k_scale_clamp
// Divides the kernel sum by the mode's constant and clamps to 0..255.
// ----------------------------------------------------------------------------
module c3k_scale_clamp (
    input  logic signed [c3k_pkg::SUM_W-1:0] sum,
    input  c3k_pkg::c3k_mode_t               mode,
    output logic [c3k_pkg::PIX_W-1:0]        pixel
);

    localparam int X_W = c3k_pkg::SUM_W - 1;
    localparam int P_W = X_W + c3k_pkg::RECIP_W;
    localparam int Q_W = P_W - c3k_pkg::RECIP_SHIFT;

    logic [X_W-1:0] mag;
    logic [P_W-1:0] prod;
    logic [Q_W-1:0] quot;

    // Negative sums give a quotient of zero or less: clamp to zero
    assign mag  = sum[c3k_pkg::SUM_W-1] ? '0 : sum[X_W-1:0];
    // Reciprocal multiply, exact for the sum range
    assign prod = P_W'(mag) * P_W'(c3k_pkg::RECIP[mode]);
    assign quot = prod[P_W-1:c3k_pkg::RECIP_SHIFT];

    // Saturate at full scale
    assign pixel = (quot > Q_W'(255)) ? c3k_pkg::PIX_W'(255)
                                      : quot[c3k_pkg::PIX_W-1:0];

endmodule

### design/conv3x3_kernel_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_kernel_filter
// 3x3 convolution on a raster grayscale stream; output is the interior image.
// ----------------------------------------------------------------------------
// Path: an input transaction passes stage A (line memory read), the window load
//   and the kernel sum, then scale and clamp into the output register to m_tvalid.
// Throughput: one pixel per clock; s_tready drops only while the skid stage
//   holds a result that the output register could not pass on.
// Reset: aresetn (synchronous, active low) clears the pipeline, the counters
//   and the registers (mode 0, width and height 2048); line memories are not
//   cleared, as every window is refilled from the current frame.
module conv3x3_kernel_filter #(
    parameter int MAX_WIDTH  = c3k_pkg::C3K_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3k_pkg::C3K_MAX_HEIGHT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration write port
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_addr,
    input  logic [c3k_pkg::CFG_W-1:0]   cfg_wdata,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,    // [7:0] pixel
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,    // [7:0] filtered_pixel
    output logic                        m_tlast,    // end_of_row
    output logic [0:0]                  m_tuser     // [0] end_of_frame
);

    `include "conv3x3_kernel_filter_assert.svh"

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int RB = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CWW = (WW > c3k_pkg::CFG_W) ? WW : c3k_pkg::CFG_W;
    localparam int CWH = (HW > c3k_pkg::CFG_W) ? HW : c3k_pkg::CFG_W;

    c3k_pkg::c3k_mode_t          mode_reg;
    logic [c3k_pkg::CFG_W-1:0]   width_reg;
    logic [c3k_pkg::CFG_W-1:0]   height_reg;
    logic [CB-1:0]               col_reg;
    logic [CB-1:0]               col_next;
    logic [RB-1:0]               row_reg;
    logic [RB-1:0]               row_next;
    logic [WW-1:0]               eff_w;
    logic [HW-1:0]               eff_h;
    logic                        last_col;
    logic                        last_row;
    logic                        en;
    logic                        accept;
    c3k_pkg::c3k_tag_t           in_tag;

    logic                        a_valid_reg;
    logic [c3k_pkg::PIX_W-1:0]   a_px_reg;
    logic [CB-1:0]               a_addr_reg;
    c3k_pkg::c3k_tag_t           a_tag_reg;

    logic [c3k_pkg::PIX_W-1:0]   upper_q;
    logic [c3k_pkg::PIX_W-1:0]   middle_q;

    logic                        s_valid;
    logic signed [c3k_pkg::SUM_W-1:0] s_sum;
    c3k_pkg::c3k_mode_t          s_mode;
    c3k_pkg::c3k_tag_t           s_tag;
    logic [c3k_pkg::PIX_W-1:0]   scaled_px;
    logic                        res_vld;
    c3k_pkg::c3k_result_t        res;

    logic                        m_valid_reg;
    c3k_pkg::c3k_result_t        out_reg;
    logic                        skid_valid_reg;
    c3k_pkg::c3k_result_t        skid_reg;

    // Frame size clamped to 3..MAX
    always_comb begin
        if (width_reg < c3k_pkg::CFG_W'(3)) begin
            eff_w = WW'(3);
        end else if (CWW'(width_reg) > CWW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(width_reg);
        end
        if (height_reg < c3k_pkg::CFG_W'(3)) begin
            eff_h = HW'(3);
        end else if (CWH'(height_reg) > CWH'(MAX_HEIGHT)) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(height_reg);
        end
    end

    // Pipeline advances unless the skid stage is occupied
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // Position of the incoming pixel
    assign last_col = (WW'(col_reg) == eff_w - WW'(1));
    assign last_row = (HW'(row_reg) == eff_h - HW'(1));
    assign in_tag.produce = (col_reg >= CB'(2)) && (row_reg >= RB'(2));
    assign in_tag.eor     = last_col;
    assign in_tag.eof     = last_col && last_row;

    always_comb begin
        col_next = col_reg + CB'(1);
        row_next = row_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + RB'(1);
        end
    end

    // Configuration registers and raster counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= c3k_pkg::MODE_BOX;
            width_reg  <= c3k_pkg::IMAGE_WIDTH_RESET;
            height_reg <= c3k_pkg::IMAGE_HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                c3k_pkg::REG_FILTER_MODE: begin
                    mode_reg <= c3k_pkg::c3k_mode_t'(cfg_wdata[1:0]);
                end
                c3k_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wdata;
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                c3k_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wdata;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage A: pixel waits for its column's line memory read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_px_reg   <= s_tdata;
            a_addr_reg <= col_reg;
            a_tag_reg  <= in_tag;
        end
    end

    c3k_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk     (aclk),
        .en       (en),
        .rd_addr  (col_reg),
        .wr_en    (en && a_valid_reg),
        .wr_addr  (a_addr_reg),
        .wr_px    (a_px_reg),
        .upper_q  (upper_q),
        .middle_q (middle_q)
    );

    c3k_window_sum u_window_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a_valid_reg),
        .in_px     (a_px_reg),
        .in_upper  (upper_q),
        .in_middle (middle_q),
        .in_tag    (a_tag_reg),
        .mode      (mode_reg),
        .out_valid (s_valid),
        .out_sum   (s_sum),
        .out_mode  (s_mode),
        .out_tag   (s_tag)
    );

    c3k_scale_clamp u_scale_clamp (
        .sum   (s_sum),
        .mode  (s_mode),
        .pixel (scaled_px)
    );

    // Only interior pixels become results
    assign res_vld   = en && s_valid && s_tag.produce;
    assign res.pixel = scaled_px;
    assign res.eor   = s_tag.eor;
    assign res.eof   = s_tag.eof;

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= res_vld;
            end
        end else if (res_vld) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (res_vld) begin
                out_reg <= res;
            end
        end else if (res_vld) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = out_reg.pixel;
    assign m_tlast    = out_reg.eor;
    assign m_tuser[0] = out_reg.eof;

    // Checks
    `C3K_ASSERT(a_skid_needs_out, aclk, aresetn, !skid_valid_reg || m_valid_reg)
    `C3K_ASSERT(a_eof_is_eor, aclk, aresetn, !(m_valid_reg && out_reg.eof) || out_reg.eor)
    `C3K_ASSERT(a_col_in_frame, aclk, aresetn, WW'(col_reg) < eff_w)
    `C3K_ASSERT_NEXT(a_skid_drains, aclk, aresetn, m_valid_reg && m_tready && skid_valid_reg, m_valid_reg && !skid_valid_reg)

endmodule

### dv/tb_conv3x3_kernel_filter.sv
// ----------------------------------------------------------------------------
// tb_conv3x3_kernel_filter
// Self-checking bench for the 3x3 convolution filter: a cycle-free pixel
// model predicts every interior result, which is compared field by field
// with the result stream under random idling and backpressure on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Pixel-level model of the filter plus the queue of results it predicts
class filtered_pixel_model;
    byte unsigned         upper_line [c3k_pkg::C3K_MAX_WIDTH];
    byte unsigned         middle_line [c3k_pkg::C3K_MAX_WIDTH];
    byte unsigned         win_px [3][3];
    c3k_pkg::c3k_mode_t   mode;
    logic [11:0]          width_reg;
    logic [11:0]          height_reg;
    int unsigned          col;
    int unsigned          row;
    int unsigned          mismatches;
    c3k_pkg::c3k_result_t expected_pixels [$];

    // Kernel weights per mode, row 0 is the oldest line
    int kern [4][3][3] = '{
        '{'{1, 1, 1}, '{1, 1, 1}, '{1, 1, 1}},
        '{'{1, 2, 1}, '{2, 4, 2}, '{1, 2, 1}},
        '{'{0, -2, 0}, '{-2, 11, -2}, '{0, -2, 0}},
        '{'{-1, -1, -1}, '{-1, 9, -1}, '{-1, -1, -1}}
    };
    int divisor [4] = '{9, 16, 3, 1};

    function new();
        foreach (upper_line[i]) begin
            upper_line[i]  = 0;
            middle_line[i] = 0;
        end
        foreach (win_px[i, j]) win_px[i][j] = 0;
        mode        = c3k_pkg::MODE_BOX;
        width_reg   = 12'd2048;
        height_reg  = 12'd2048;
        col         = 0;
        row         = 0;
        mismatches  = 0;
    endfunction

    // Frame dimensions are clamped to 3..max
    function int unsigned clamp_dim(logic [11:0] v, int unsigned hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function void write_reg(logic [1:0] idx, logic [11:0] val);
        case (idx)
            c3k_pkg::REG_FILTER_MODE: begin
                mode = c3k_pkg::c3k_mode_t'(val[1:0]);
            end
            c3k_pkg::REG_IMAGE_WIDTH: begin
                width_reg = val;
                col = 0;
                row = 0;
            end
            c3k_pkg::REG_IMAGE_HEIGHT: begin
                height_reg = val;
                col = 0;
                row = 0;
            end
            default: begin
            end
        endcase
    endfunction

    // One accepted pixel: update line stores and window, predict a result
    function void accept_pixel(logic [7:0] px);
        int unsigned          w;
        int unsigned          h;
        int unsigned          c;
        int unsigned          r;
        int                   m;
        int                   acc;
        int                   q;
        c3k_pkg::c3k_result_t res;
        w = clamp_dim(width_reg, c3k_pkg::C3K_MAX_WIDTH);
        h = clamp_dim(height_reg, c3k_pkg::C3K_MAX_HEIGHT);
        c = col;
        r = row;
        if (c >= w) c = 0;
        if (r >= h) r = 0;

        for (int i = 0; i < 3; i++) begin
            win_px[i][0] = win_px[i][1];
            win_px[i][1] = win_px[i][2];
        end
        win_px[0][2]   = upper_line[c];
        win_px[1][2]   = middle_line[c];
        win_px[2][2]   = px;
        upper_line[c]  = middle_line[c];
        middle_line[c] = px;

        // Interior pixel: window is complete
        if (r >= 2 && c >= 2) begin
            m   = int'(mode);
            acc = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    acc += kern[m][i][j] * int'(win_px[i][j]);
            q = acc / divisor[m];
            if (q > 255)
                q = 255;
            else if (q < 0)
                q = 0;
            res.pixel = q[7:0];
            res.eor   = (c == w - 1);
            res.eof   = (c == w - 1) && (r == h - 1);
            expected_pixels.push_back(res);
        end

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col = c;
        row = r;
    endfunction

    task report(string what);
        mismatches++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    task check_filtered(logic [7:0] px, logic eor, logic eof);
        c3k_pkg::c3k_result_t want;
        if (expected_pixels.size() == 0) begin
            report($sformatf("unexpected result pixel=%0d", px));
        end else begin
            want = expected_pixels.pop_front();
            if (px !== want.pixel)
                report($sformatf("pixel got %0d want %0d", px, want.pixel));
            if (eor !== want.eor)
                report($sformatf("end_of_row got %0b want %0b", eor, want.eor));
            if (eof !== want.eof)
                report($sformatf("end_of_frame got %0b want %0b", eof, want.eof));
        end
    endtask
endclass

module tb_conv3x3_kernel_filter;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 850;
    localparam int HOLD_CYCLES    = 300;
    localparam int WIDE_ITEMS     = 200;
    localparam int TALL_ROWS      = 80;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = 2'd0;
    logic [11:0] cfg_wdata = 12'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    filtered_pixel_model pix_model;

    bit          src_idle   = 1'b1;
    bit          dst_idle   = 1'b1;
    int          hold_len   = 0;
    int          idle_count = 0;
    int unsigned random_items = 0;
    logic [11:0] cur_w = 12'd2048;
    logic [11:0] cur_h = 12'd2048;

    conv3x3_kernel_filter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] pixel
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [7:0] filtered_pixel
        .m_tlast   (m_tlast),     // end_of_row
        .m_tuser   (m_tuser)      // [0] end_of_frame
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Monitor: every transaction and register write feeds the model
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                pix_model.write_reg(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready)
                pix_model.accept_pixel(s_tdata);
            if (m_tvalid && m_tready)
                pix_model.check_filtered(m_tdata, m_tlast, m_tuser[0]);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("[conv3x3_kernel_filter] ERROR");
            $finish;
        end
    end

    // Result receiver: random stalls, plus one long hold on request
    initial begin
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = dst_idle ? $urandom_range(0, 5) : 0;
            if (hold_len > 0) begin
                gap      = hold_len;
                hold_len = 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Pixel draw biased toward the extremes so clamping is hit often
    function automatic logic [7:0] draw_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] px);
        int gap;
        gap = src_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Register write, one per cycle; caller lowers the enable after a batch
    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == c3k_pkg::REG_IMAGE_WIDTH)  cur_w = val;
        if (idx == c3k_pkg::REG_IMAGE_HEIGHT) cur_h = val;
        @(posedge aclk);
    endtask

    // Stop sending, let every predicted result arrive and the pipe empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pix_model.expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [11:0] draw_dim();
        case ($urandom_range(0, 19))
            0:       return 12'($urandom_range(0, 2));
            1:       return 12'($urandom_range(2049, 4095));
            default: return 12'($urandom_range(3, 12));
        endcase
    endfunction

    // One random phase: a few register writes, then whole frames with an
    // occasional broken tail; long frames get a short partial run instead
    task automatic run_random_phase(input bit pressure);
        int          n_writes;
        logic [1:0]  idx;
        logic [11:0] val;
        int unsigned frame_px;
        int unsigned len;
        wait_drained();
        n_writes = $urandom_range(0, 4);
        for (int k = 0; k < n_writes; k++) begin
            idx = 2'($urandom_range(0, 3));
            case (idx)
                c3k_pkg::REG_IMAGE_WIDTH, c3k_pkg::REG_IMAGE_HEIGHT: val = draw_dim();
                default:                                              val = 12'($urandom);
            endcase
            write_reg(idx, val);
        end
        if (pressure) begin
            write_reg(c3k_pkg::REG_IMAGE_WIDTH, 12'd8);
            write_reg(c3k_pkg::REG_IMAGE_HEIGHT, 12'd8);
        end
        cfg_wr_en <= 1'b0;

        frame_px = pix_model.clamp_dim(cur_w, c3k_pkg::C3K_MAX_WIDTH) *
                   pix_model.clamp_dim(cur_h, c3k_pkg::C3K_MAX_HEIGHT);
        if (frame_px <= 160) begin
            len = frame_px * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0)
                len += $urandom_range(1, frame_px - 1);
        end else begin
            len = $urandom_range(20, 200);
        end

        src_idle = pressure ? 1'b0 : ($urandom_range(0, 3) != 0);
        dst_idle = ($urandom_range(0, 3) != 0);
        if (pressure)
            hold_len = HOLD_CYCLES;
        for (int unsigned k = 0; k < len; k++) begin
            send_pixel(draw_pixel());
            random_items++;
        end
    endtask

    initial begin
        logic [11:0] val;
        int          phase;
        pix_model = new();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset dimensions: a few pixels, no window completes
        repeat (5) send_pixel(draw_pixel());
        wait_drained();

        // Out-of-range dimensions clamp to 3x3; mode with high bits set
        write_reg(c3k_pkg::REG_IMAGE_WIDTH, 12'd2);
        write_reg(c3k_pkg::REG_IMAGE_HEIGHT, 12'd1);
        write_reg(c3k_pkg::REG_FILTER_MODE, 12'hFFF);
        cfg_wr_en <= 1'b0;
        // Mean removal on a lone bright center: clamps high
        for (int i = 0; i < 9; i++)
            send_pixel(i == 4 ? 8'hFF : 8'h00);
        wait_drained();

        // Sharpen on a dark center: clamps low; unmapped index is ignored
        val = 12'h5A4;
        val[1:0] = c3k_pkg::MODE_SHARPEN;
        write_reg(c3k_pkg::REG_FILTER_MODE, val);
        write_reg(REG_UNMAPPED, 12'hFFF);
        cfg_wr_en <= 1'b0;
        for (int i = 0; i < 9; i++)
            send_pixel(i == 4 ? 8'h00 : 8'hFF);
        wait_drained();

        // Widest frame (width written above the maximum): part of the top row
        val = 12'h000;
        val[1:0] = c3k_pkg::MODE_GAUSS;
        write_reg(c3k_pkg::REG_FILTER_MODE, val);
        write_reg(c3k_pkg::REG_IMAGE_WIDTH, 12'hFFF);
        write_reg(c3k_pkg::REG_IMAGE_HEIGHT, 12'd3);
        cfg_wr_en <= 1'b0;
        src_idle = 1'b0;
        dst_idle = 1'b1;
        repeat (WIDE_ITEMS) send_pixel(draw_pixel());
        wait_drained();

        // Tallest frame, three columns, first rows only
        val = 12'hA50;
        val[1:0] = c3k_pkg::MODE_MEAN_REMOVAL;
        write_reg(c3k_pkg::REG_FILTER_MODE, val);
        write_reg(c3k_pkg::REG_IMAGE_WIDTH, 12'd3);
        write_reg(c3k_pkg::REG_IMAGE_HEIGHT, 12'd2048);
        cfg_wr_en <= 1'b0;
        src_idle = 1'b1;
        dst_idle = 1'b0;
        repeat (TALL_ROWS * 3) send_pixel(draw_pixel());

        // Random phases, the first one under a long receiver hold
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            run_random_phase(phase == 0);
            phase++;
        end

        wait_drained();
        if (pix_model.mismatches == 0 && pix_model.expected_pixels.size() == 0)
            $display("[conv3x3_kernel_filter] OK");
        else
            $display("[conv3x3_kernel_filter] ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/c3k_pkg.sv
design/c3k_line_buf.sv
design/c3k_window_sum.sv
design/c3k_scale_clamp.sv
design/conv3x3_kernel_filter.sv
dv/tb_conv3x3_kernel_filter.sv
